### rtl/core/rlfe_pkg.sv
package rlfe_pkg;

    localparam int CH      = 3;
    localparam int LEVEL_W = 8;
    localparam int RATE_W  = 16;
    localparam int TIME_W  = 24;
    localparam int NUM_W   = LEVEL_W + TIME_W;
    localparam int CH_W    = (CH > 1) ? $clog2(CH) : 1;
    localparam int CNT_W   = $clog2(LEVEL_W);
    localparam int CFG_W   = 2;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_e_t;

    typedef enum logic [CFG_W-1:0] {
        REG_ON_RED   = 2'd0,
        REG_ON_GREEN = 2'd1,
        REG_ON_BLUE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [RATE_W-1:0]  fade_rate;
    } in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] duty_red;
        logic [LEVEL_W-1:0] duty_green;
        logic [LEVEL_W-1:0] duty_blue;
        logic [LEVEL_W-1:0] target_red;
        logic [LEVEL_W-1:0] target_green;
        logic [LEVEL_W-1:0] target_blue;
        logic               fading;
    } out_t;

    typedef struct packed {
        logic latch;
        logic toggle;
        logic begin_fade;
        logic tick_dec;
        logic finish;
        logic mul1;
        logic mul2;
        logic div_step;
        logic ch_inc;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic rem_one;
        logic div_last;
        logic ch_last;
    } dp_sts_t;

endpackage

### rtl/core/rgb_linear_fade_engine_top.sv
// Channel | Direction | Signals                            | Transfer when
// input   | in        | in_valid, in_stall, in_data        | in_valid & !in_stall
// output  | out       | out_valid, out_stall, out_data     | out_valid & !out_stall
// config  | in        | cfg_we, cfg_index, cfg_data        | cfg_we
//
// Set or toggle: latch, then one 8x16 multiply for the fade length.
// Tick in a fade: the decrement, then two multiplies and the shared 8-step
// restoring divider, run once per channel. Reset clears control and fade state.
// Idle tick or unused command: to done; last tick of a fade: decrement, finish.
// The done state moves the result to the output register once it is free; the
// next item is taken while that result waits under out_stall.
module rgb_linear_fade_engine_top
    import rlfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_t               out_data,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_index,
    input  logic [LEVEL_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rlfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (in_data.command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlfe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

### rtl/core/rlfe_dp.sv
module rlfe_dp
    import rlfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  in_t                in_data,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_index,
    input  logic [LEVEL_W-1:0] cfg_data,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output out_t               out_data
);

    logic [LEVEL_W-1:0] on_reg     [CH];
    logic [LEVEL_W-1:0] duty_reg   [CH];
    logic [LEVEL_W-1:0] start_reg  [CH];
    logic [LEVEL_W-1:0] target_reg [CH];
    logic [TIME_W-1:0]  rem_reg;
    logic [TIME_W-1:0]  total_reg;
    logic [LEVEL_W-1:0] maxd_reg;
    logic [LEVEL_W-1:0] maxd_next;
    logic [RATE_W-1:0]  rate_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [NUM_W-1:0]   prod_reg;
    logic [TIME_W-1:0]  r_reg;
    logic [LEVEL_W-1:0] low_reg;
    logic [LEVEL_W-1:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    out_t               out_reg;

    logic [LEVEL_W-1:0] lvl       [CH];
    logic [LEVEL_W-1:0] in_lvl    [CH];
    logic [LEVEL_W-1:0] lvl_gap   [CH];
    logic               any_on;
    logic [TIME_W-1:0]  total_calc;
    logic [TIME_W-1:0]  elapsed;
    logic [NUM_W-1:0]   num;
    logic [TIME_W:0]    rr;
    logic [TIME_W:0]    rr_sub;
    logic               ge;
    logic [LEVEL_W-1:0] q_new;

    assign in_lvl[0] = in_data.red_level;
    assign in_lvl[1] = in_data.green_level;
    assign in_lvl[2] = in_data.blue_level;

    always_comb
    begin
        any_on    = 1'b0;
        maxd_next = '0;
        for (int i = 0; i < CH; i++)
        begin
            any_on = any_on | (target_reg[i] != '0);
        end
        for (int i = 0; i < CH; i++)
        begin
            if (cmd.toggle)
            begin
                lvl[i] = any_on ? '0 : on_reg[i];
            end
            else
            begin
                lvl[i] = in_lvl[i];
            end
            lvl_gap[i] = (lvl[i] > duty_reg[i]) ? (lvl[i] - duty_reg[i])
                                                 : (duty_reg[i] - lvl[i]);
            if (lvl_gap[i] > maxd_next)
            begin
                maxd_next = lvl_gap[i];
            end
        end
    end

    assign total_calc = TIME_W'(maxd_reg) * TIME_W'(rate_reg);
    assign elapsed    = total_reg - rem_reg;
    assign num        = prod_reg + NUM_W'(start_reg[ch_reg]) * NUM_W'(rem_reg);
    assign rr         = {r_reg, low_reg[LEVEL_W-1]};
    assign rr_sub     = rr - {1'b0, total_reg};
    assign ge         = (rr >= {1'b0, total_reg});
    assign q_new      = {q_reg[LEVEL_W-2:0], ge};

    assign sts.rem_zero = (rem_reg == '0);
    assign sts.rem_one  = (rem_reg == TIME_W'(1));
    assign sts.div_last = (cnt_reg == CNT_W'(LEVEL_W - 1));
    assign sts.ch_last  = (ch_reg == CH_W'(CH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH; i++)
            begin
                on_reg[i]     <= '1;
                duty_reg[i]   <= '0;
                start_reg[i]  <= '0;
                target_reg[i] <= '0;
            end
            rem_reg   <= '0;
            total_reg <= '0;
            ch_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ON_RED:   on_reg[0] <= cfg_data;
                    REG_ON_GREEN: on_reg[1] <= cfg_data;
                    REG_ON_BLUE:  on_reg[2] <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.latch)
            begin
                for (int i = 0; i < CH; i++)
                begin
                    start_reg[i]  <= duty_reg[i];
                    target_reg[i] <= lvl[i];
                end
            end
            if (cmd.begin_fade)
            begin
                if (rate_reg == '0 || maxd_reg == '0)
                begin
                    for (int i = 0; i < CH; i++)
                    begin
                        duty_reg[i] <= target_reg[i];
                    end
                    rem_reg   <= '0;
                    total_reg <= '0;
                end
                else
                begin
                    rem_reg   <= total_calc;
                    total_reg <= total_calc;
                end
            end
            if (cmd.tick_dec)
            begin
                rem_reg <= rem_reg - TIME_W'(1);
                ch_reg  <= '0;
            end
            if (cmd.finish)
            begin
                for (int i = 0; i < CH; i++)
                begin
                    duty_reg[i] <= target_reg[i];
                end
            end
            if (cmd.mul2)
            begin
                cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (sts.div_last)
                begin
                    duty_reg[ch_reg] <= q_new;
                end
            end
            if (cmd.ch_inc)
            begin
                ch_reg <= ch_reg + CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            maxd_reg <= maxd_next;
            rate_reg <= in_data.fade_rate;
        end
        if (cmd.mul1)
        begin
            prod_reg <= NUM_W'(target_reg[ch_reg]) * NUM_W'(elapsed);
        end
        if (cmd.mul2)
        begin
            r_reg   <= num[NUM_W-1:LEVEL_W];
            low_reg <= num[LEVEL_W-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            r_reg   <= ge ? rr_sub[TIME_W-1:0] : rr[TIME_W-1:0];
            low_reg <= {low_reg[LEVEL_W-2:0], 1'b0};
            q_reg   <= q_new;
        end
        if (cmd.load_out)
        begin
            out_reg.duty_red     <= duty_reg[0];
            out_reg.duty_green   <= duty_reg[1];
            out_reg.duty_blue    <= duty_reg[2];
            out_reg.target_red   <= target_reg[0];
            out_reg.target_green <= target_reg[1];
            out_reg.target_blue  <= target_reg[2];
            out_reg.fading       <= (rem_reg != '0);
        end
    end

    assign out_data = out_reg;

    a_rem_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg <= total_reg))
        else $error("remaining time exceeds fade length");

    a_div_keeps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (r_reg < total_reg))
        else $error("divider remainder not below divisor");

    a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ch_reg <= CH_W'(CH - 1)))
        else $error("channel index out of range");

endmodule

### rtl/core/rlfe_ctrl.sv
module rlfe_ctrl
    import rlfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] command,
    output logic             out_valid,
    input  logic             out_stall,
    input  dp_sts_t          sts,
    output dp_cmd_t          cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_BEGIN  = 7'b0000010,
        ST_FINISH = 7'b0000100,
        ST_MUL1   = 7'b0001000,
        ST_MUL2   = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_SET:
                        begin
                            cmd.latch  = 1'b1;
                            state_next = ST_BEGIN;
                        end
                        CMD_TOGGLE:
                        begin
                            cmd.latch  = 1'b1;
                            cmd.toggle = 1'b1;
                            state_next = ST_BEGIN;
                        end
                        CMD_TICK:
                        begin
                            if (sts.rem_zero)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cmd.tick_dec = 1'b1;
                                state_next   = sts.rem_one ? ST_FINISH : ST_MUL1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_BEGIN:
            begin
                cmd.begin_fade = 1'b1;
                state_next     = ST_DONE;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    if (sts.ch_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.ch_inc = 1'b1;
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result register loaded while holding an untaken transfer");

    a_next_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last && !sts.ch_last) |=> (state_reg == ST_MUL1))
        else $error("divider did not move on to next channel");

    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result load did not return to idle with valid set");

endmodule
